[sv/dtc_pkg.sv]
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared constants and types for the decision tree classifier.
// ----------------------------------------------------------------------------
package dtc_pkg;

    localparam int TREE_DEPTH   = 6;
    localparam int NUM_FEATURES = 16;
    localparam int VALUE_WIDTH  = 32;

    localparam int NODE_COUNT = (1 << TREE_DEPTH) - 1;
    localparam int LEAF_COUNT = 1 << TREE_DEPTH;

    // item field widths
    localparam int OPCODE_W = 2;
    localparam int LEVEL_W  = 3;
    localparam int SLOT_W   = 6;
    localparam int FNUM_W   = 4;
    localparam int LABEL_W  = 8;
    localparam int LEAF_W   = 6;

    localparam int NODE_IDX_W = TREE_DEPTH;
    localparam int LVL_W      = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
    localparam int FEAT_IDX_W = $clog2(NUM_FEATURES);

    localparam int IN_FIELDS_W  = LEVEL_W + SLOT_W + FNUM_W + VALUE_WIDTH + LABEL_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = LABEL_W + LEAF_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_WRITE_NODE    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE_LEAF    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE_FEATURE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_CLASSIFY      = 2'd3;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        logic [FNUM_W-1:0] feat;
        value_t            thr;
    } node_entry_t;

endpackage

[sv/decision_tree_classifier.sv]
// ----------------------------------------------------------------------------
// decision_tree_classifier
// Complete binary decision tree inference over a stored feature vector.
// ----------------------------------------------------------------------------
// Input stream carries opcode items in tuser: node write, leaf write,
// feature write and classify. Write items are taken one per cycle while the
// input is ready, and complete in the cycle they are accepted; they produce no output.
// A classify item walks the tree from the root, one level per cycle: the
// node table read issued in one cycle is compared against the selected
// feature in the next, which also issues the read for the child node.
// After the last level the leaf class memory is read.
// The input is not ready during the walk and the leaf state, so a new item
// is accepted only after the classify result has been loaded into the
// output register.
// Output is a register: a waiting result does not block the next input
// transfer; only a second result that finds the register still full holds
// the walk in its final state until the receiver takes the first.
// Reset clears control state only; tables are undefined until written.
module decision_tree_classifier (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // node_level, slot, feature_number, value, leaf_label (low bit up), zero pad
    input  logic [dtc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [dtc_pkg::OPCODE_W-1:0]    s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // class_label, leaf_reached (low bit up), zero pad
    output logic [dtc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import dtc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_LEAF = 2'd2;

    // input field unpacking
    logic [LEVEL_W-1:0] in_level;
    logic [SLOT_W-1:0]  in_slot;
    logic [FNUM_W-1:0]  in_fnum;
    value_t             in_value;
    logic [LABEL_W-1:0] in_label;

    assign in_level = s_axis_tdata[LEVEL_W-1:0];
    assign in_slot  = s_axis_tdata[LEVEL_W +: SLOT_W];
    assign in_fnum  = s_axis_tdata[LEVEL_W+SLOT_W +: FNUM_W];
    assign in_value = s_axis_tdata[LEVEL_W+SLOT_W+FNUM_W +: VALUE_WIDTH];
    assign in_label = s_axis_tdata[LEVEL_W+SLOT_W+FNUM_W+VALUE_WIDTH +: LABEL_W];

    logic [1:0]             state_reg, state_next;
    logic [LVL_W-1:0]       lvl_reg, lvl_next;
    logic [TREE_DEPTH-1:0]  row_reg, row_next;
    logic [NODE_IDX_W-1:0]  idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic [LABEL_W-1:0]     out_label_reg;
    logic [LEAF_W-1:0]      out_leaf_reg;

    logic in_xfer;
    logic out_free;
    logic last_level;
    logic go_right;
    logic [TREE_DEPTH-1:0] child_row;
    logic [NODE_IDX_W-1:0] child_idx;
    value_t                feat_val;

    // node table ports
    logic                  node_we;
    logic [NODE_IDX_W-1:0] node_waddr;
    node_entry_t           node_wdata;
    logic                  node_re;
    logic [NODE_IDX_W-1:0] node_raddr;
    node_entry_t           node_q;

    // leaf table and feature registers
    logic [LABEL_W-1:0] leaf_mem [LEAF_COUNT];
    logic [LABEL_W-1:0] leaf_q;
    logic               leaf_re;
    value_t             feat_store [NUM_FEATURES];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // ---------------- writes ----------------
    always_comb
    begin
        node_we    = 1'b0;
        node_waddr = NODE_IDX_W'((1 << in_level) - 1 + int'(in_slot));
        node_wdata = '{feat: in_fnum, thr: in_value};
        if (in_xfer && s_axis_tuser == OP_WRITE_NODE &&
            int'(in_level) < TREE_DEPTH && (int'(in_slot) >> in_level) == 0)
        begin
            node_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && s_axis_tuser == OP_WRITE_LEAF && int'(in_slot) < LEAF_COUNT)
        begin
            leaf_mem[in_slot[TREE_DEPTH-1:0]] <= in_label;
        end
        if (leaf_re)
        begin
            leaf_q <= leaf_mem[child_row];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && s_axis_tuser == OP_WRITE_FEATURE && int'(in_fnum) < NUM_FEATURES)
        begin
            feat_store[in_fnum[FEAT_IDX_W-1:0]] <= in_value;
        end
    end

    // ---------------- walk ----------------
    always_comb
    begin
        feat_val = '0;
        if (int'(node_q.feat) < NUM_FEATURES)
        begin
            feat_val = feat_store[node_q.feat[FEAT_IDX_W-1:0]];
        end
    end

    assign go_right   = (feat_val > node_q.thr);
    assign last_level = (lvl_reg == LVL_W'(TREE_DEPTH - 1));
    assign child_row  = {row_reg[TREE_DEPTH-2:0], go_right};
    // heap order: children of node i are 2i+1 and 2i+2
    assign child_idx  = {idx_reg[NODE_IDX_W-2:0], 1'b1} + NODE_IDX_W'(go_right);

    assign node_re    = (in_xfer && s_axis_tuser == OP_CLASSIFY) ||
                        (state_reg == ST_WALK && !last_level);
    assign node_raddr = (state_reg == ST_IDLE) ? '0 : child_idx;
    assign leaf_re    = (state_reg == ST_WALK) && last_level;

    dtc_node_mem u_node_mem (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        row_next       = row_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && s_axis_tuser == OP_CLASSIFY)
                begin
                    state_next = ST_WALK;
                    lvl_next   = '0;
                    row_next   = '0;
                    idx_next   = '0;
                end
            end
            ST_WALK:
            begin
                row_next = child_row;
                idx_next = child_idx;
                lvl_next = lvl_reg + 1'b1;
                if (last_level)
                begin
                    state_next = ST_LEAF;
                end
            end
            ST_LEAF:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lvl_reg       <= '0;
            row_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            row_reg       <= row_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LEAF && out_free)
        begin
            out_label_reg <= leaf_q;
            out_leaf_reg  <= LEAF_W'(row_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_leaf_reg, out_label_reg});

`ifndef ASSERT_OFF
    a_walk_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> lvl_reg <= LVL_W'(TREE_DEPTH - 1))
        else $error("walk level beyond tree depth");

    a_classify_starts_at_root: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && s_axis_tuser == OP_CLASSIFY |=>
        state_reg == ST_WALK && lvl_reg == '0 && row_reg == '0 && idx_reg == '0)
        else $error("classify did not start at root");

    a_leaf_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LEAF && out_free |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished walk not loaded into output");

    a_no_node_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(node_we && node_re))
        else $error("node table written during walk");
`endif

endmodule

[sv/dtc_node_mem.sv]
// ----------------------------------------------------------------------------
// dtc_node_mem
// Node table: feature index and threshold per tree node, heap ordered,
// one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dtc_node_mem (
    input  logic                            clk,
    input  logic                            we,
    input  logic [dtc_pkg::NODE_IDX_W-1:0]  waddr,
    input  dtc_pkg::node_entry_t            wdata,
    input  logic                            re,
    input  logic [dtc_pkg::NODE_IDX_W-1:0]  raddr,
    output dtc_pkg::node_entry_t            rdata
);
    import dtc_pkg::*;

    node_entry_t mem [NODE_COUNT];
    node_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
